[hdl/arfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_pkg
// Shared constants and types for the audio ring FIFO with block RMS read-out.
// ----------------------------------------------------------------------------
package arfb_pkg;

    // Ring and block geometry (DEPTH and BLOCK are powers of two)
    localparam int DEPTH    = 4096;
    localparam int BLOCK    = 64;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = (BLOCK > 1) ? $clog2(BLOCK) : 1;
    localparam int BLK_SHIFT = $clog2(BLOCK);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int FILL_W   = 12;
    localparam int TOTAL_W  = 32;
    localparam int MODE_W   = 2;

    // Square of a Q1.15 sample peaks at 2^30, so 31 bits unsigned
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int ACC_W    = SQ_W + BLK_SHIFT;
    localparam int ROOT_TOP = 2 * (SAMPLE_W - 1);

    // Stream packing
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 80;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_WAIT,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_HOLD
    } state_t;

    typedef enum logic [1:0] {
        KIND_BLOCK,
        KIND_UNDER,
        KIND_QUERY
    } kind_t;

endpackage

[hdl/audio_ring_fifo_block_rms_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_ring_fifo_block_rms_top
// Audio sample ring FIFO (overwrite oldest) with block read-out and RMS level.
// ----------------------------------------------------------------------------
// Write item: no result; the next item is taken in the following cycle.
// Read item: a square-sum pass over the RAM read port, then the iterative
//   square root, then the result samples, each read and held until taken.
// Underrun read: a block of zero samples flagged underrun; query: one result.
// Reset (rst_n low, asynchronous): pointers, underrun count and level clear,
//   enable sets to 1; sample RAM contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module audio_ring_fifo_block_rms_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: enable register
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [arfb_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] sample_in
    input  logic [arfb_pkg::MODE_W-1:0]    s_tuser,   // [1:0] mode
    // Output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [arfb_pkg::M_DATA_W-1:0]  m_tdata,   // [15:0] sample_out,
                                                      // [31:16] level,
                                                      // [43:32] fill_count,
                                                      // [75:44] underrun_total,
                                                      // [79:76] zero
    output logic                           m_tlast,   // last
    output logic                           m_tuser    // underrun
);
    import arfb_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK - 1);
    localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_BLK  = PTR_W'(BLOCK);

    state_t             state_reg, state_next;
    kind_t              kind_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   base_reg;
    logic [TOTAL_W-1:0] under_cnt_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               enable_reg;
    logic               rd_vld_reg;

    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [FILL_W-1:0]   out_fill_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic                out_last_reg;
    logic                out_under_reg;
    logic                m_tvalid_reg;

    logic               in_xfer;
    logic               out_xfer;
    logic [PTR_W-1:0]   used;
    logic               short_read;
    logic [MODE_W-1:0]  in_mode;

    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [PTR_W-1:0]   ram_rd_addr;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic               mac_clear;
    logic               mac_busy;
    logic [ACC_W-1:0]   mac_acc;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [LEVEL_W-1:0] sqrt_root;
    logic               load_out;

    assign in_mode    = s_tuser;
    assign in_xfer    = s_tvalid && s_tready;
    assign out_xfer   = m_tvalid_reg && m_tready;
    assign used       = wr_ptr_reg - rd_ptr_reg;
    assign short_read = (used < PTR_W'(BLOCK));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_mode)
                        MODE_READ:  state_next = short_read ? ST_OUT_LOAD : ST_SUM_RD;
                        MODE_QUERY: state_next = ST_OUT_LOAD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SUM_RD:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SUM_WAIT;
                end
            end
            ST_SUM_WAIT:
            begin
                if (!rd_vld_reg && !mac_busy)
                begin
                    state_next = ST_ROOT_START;
                end
            end
            ST_ROOT_START: state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:   state_next = ST_OUT_LOAD;
            ST_OUT_LOAD: state_next = ST_OUT_HOLD;
            ST_OUT_HOLD:
            begin
                if (m_tready)
                begin
                    if (kind_reg == KIND_QUERY || cnt_reg == CNT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (kind_reg == KIND_BLOCK)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        state_next = ST_OUT_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = base_reg + PTR_W'(cnt_reg);
        mac_clear   = 1'b0;
        sqrt_start  = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_wr_en = in_xfer && (in_mode == MODE_WRITE) && enable_reg;
                mac_clear = 1'b1;
            end
            ST_SUM_RD:     ram_rd_en  = 1'b1;
            ST_ROOT_START: sqrt_start = 1'b1;
            ST_OUT_RD:     ram_rd_en  = 1'b1;
            ST_OUT_LOAD:   load_out   = 1'b1;
            default:
            begin
            end
        endcase
    end

    // Sequencer and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_QUERY;
            cnt_reg       <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            base_reg      <= '0;
            under_cnt_reg <= '0;
            level_reg     <= '0;
            enable_reg    <= 1'b1;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= ram_rd_en && (state_reg == ST_SUM_RD);

            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end

            // Accept an item
            if (in_xfer)
            begin
                cnt_reg  <= '0;
                base_reg <= rd_ptr_reg;
                case (in_mode)
                    MODE_WRITE:
                    begin
                        if (enable_reg)
                        begin
                            // Drop the oldest sample when the ring is full
                            if (used == PTR_FULL)
                            begin
                                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                            end
                            wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
                        end
                    end
                    MODE_READ:
                    begin
                        if (short_read)
                        begin
                            kind_reg      <= KIND_UNDER;
                            under_cnt_reg <= under_cnt_reg + TOTAL_W'(1);
                        end
                        else
                        begin
                            kind_reg <= KIND_BLOCK;
                        end
                    end
                    MODE_QUERY: kind_reg <= KIND_QUERY;
                    default:
                    begin
                    end
                endcase
            end

            // Advance the square-sum address
            if (state_reg == ST_SUM_RD)
            begin
                cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CNT_W'(1);
            end

            // Latch the new level and consume the block
            if (state_reg == ST_ROOT_WAIT && sqrt_done)
            begin
                level_reg  <= sqrt_root;
                rd_ptr_reg <= base_reg + PTR_BLK;
            end

            // Output register handshake
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                m_tvalid_reg <= 1'b0;
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sample_reg <= (kind_reg == KIND_BLOCK) ? ram_rd_data : '0;
            out_last_reg   <= (kind_reg == KIND_QUERY) || (cnt_reg == CNT_LAST);
            out_under_reg  <= (kind_reg == KIND_UNDER);
            out_level_reg  <= level_reg;
            out_fill_reg   <= (kind_reg == KIND_QUERY && !enable_reg) ? '0 : FILL_W'(used);
            out_total_reg  <= under_cnt_reg;
        end
    end

    arfb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata[SAMPLE_W-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    arfb_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (mac_clear),
        .in_valid  (rd_vld_reg),
        .in_sample (ram_rd_data),
        .busy      (mac_busy),
        .acc       (mac_acc)
    );

    arfb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mac_acc[BLK_SHIFT +: SQ_W]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - SAMPLE_W - LEVEL_W - FILL_W - TOTAL_W){1'b0}},
                       out_total_reg, out_fill_reg, out_level_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_under_reg;

    // No result pending while the block takes new items
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !m_tvalid_reg)
        else $error("result pending in idle");

    // Square root finishes only while the sequencer waits on it
    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_ROOT_WAIT))
        else $error("square root done outside its wait state");

    // Silence blocks carry zero samples
    a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_under_reg) |-> (out_sample_reg == '0))
        else $error("nonzero sample in underrun block");

    // A normal block has already consumed its samples when the results go out
    a_block_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && kind_reg == KIND_BLOCK) |-> (rd_ptr_reg == base_reg + PTR_BLK))
        else $error("read pointer not advanced for block");

endmodule

[hdl/arfb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/arfb_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_mac
// Square-and-accumulate unit: one registered 16x16 square per cycle, summed.
// ----------------------------------------------------------------------------
module arfb_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic                                 in_valid,
    input  logic signed [arfb_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                 busy,
    output logic [arfb_pkg::ACC_W-1:0]           acc
);
    import arfb_pkg::*;

    logic signed [2*SAMPLE_W-1:0] prod_full;
    logic [SQ_W-1:0]              prod_reg;
    logic                         prod_vld_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic [ACC_W-1:0]             acc_next;

    assign prod_full = in_sample * in_sample;
    assign acc_next  = acc_reg + {{(ACC_W - SQ_W){1'b0}}, prod_reg};

    // Register the square, then add it in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= in_valid;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[SQ_W-1:0];
    end

    assign busy = prod_vld_reg;
    assign acc  = acc_reg;

endmodule

[hdl/arfb_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfb_sqrt
// Iterative integer square root, stepping over the radicand two bits at a time.
// ----------------------------------------------------------------------------
module arfb_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [arfb_pkg::SQ_W-1:0]      radicand,
    output logic                           done,
    output logic [arfb_pkg::LEVEL_W-1:0]   root
);
    import arfb_pkg::*;

    logic [SQ_W-1:0] x_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W:0]   trial;
    logic            take;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, x_reg} >= trial);

    // Control: run until the trial bit shifts out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (bit_reg[1:0] != 2'b00))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: one compare-and-subtract step per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << ROOT_TOP;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg   <= x_reg - trial[SQ_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[LEVEL_W-1:0];

endmodule
